// ===== design/csvtok_pkg.sv =====
// Shared types and constants for the CSV field tokenizer.
// It depends on nothing. The step logic, the result register and the top level import it.
package csvtok_pkg;

  // These are the byte codes that the parser reacts to.
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [1:0] {
    MODE_PLAIN   = 2'd0,
    MODE_QUOTED  = 2'd1,
    MODE_PENDING = 2'd2,
    MODE_ERROR   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    KIND_CHAR         = 3'd0,
    KIND_FIELD_END    = 3'd1,
    KIND_RECORD_END   = 3'd2,
    KIND_STRAY_QUOTE  = 3'd3,
    KIND_UNTERMINATED = 3'd4
  } kind_e;

  // This is the parser state that is carried from one byte to the next.
  typedef struct packed {
    mode_e mode;
    logic  field_has_chars;
    logic  record_has_fields;
  } parse_state_t;

  // This is the token that one word produces, if it produces any.
  typedef struct packed {
    logic       emit;
    kind_e      kind;
    logic [7:0] char_value;
  } token_t;

  localparam parse_state_t STATE_RESET = '{
    mode: MODE_PLAIN, field_has_chars: 1'b0, record_has_fields: 1'b0
  };

endpackage

// ===== design/csv_quoted_field_tokenizer.sv =====
// CSV field tokenizer: a word is held in the input register, and its token in the result register.
// It takes one word per cycle unless the input is stalled. The parser state updates once per word.
// A word that produces no token never waits on a stalled output.
// The asynchronous active-low reset empties both registers and returns the parser to plain mode.
module csv_quoted_field_tokenizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       end_of_input_i,
  input  logic [7:0] text_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] token_kind_o,
  output logic [7:0] char_value_o
);
  import csvtok_pkg::*;

  // The input register holds one accepted word until the parser consumes it.
  logic         in_valid_q, in_valid_d;
  logic         eoi_q;
  logic [7:0]   byte_q;

  // This is the parser state: the mode plus the two flags for the field and the record.
  parse_state_t st_q, st_d;
  token_t       tok;
  logic         out_free;
  logic         s1_move;
  logic         in_accept;

  csvtok_step u_step (
    .cur_i          (st_q),
    .end_of_input_i (eoi_q),
    .text_byte_i    (byte_q),
    .nxt_o          (st_d),
    .tok_o          (tok)
  );

  // The buffered word is consumed when it produces no token or when the result slot is free.
  // The state then commits and any token is loaded into the result register.
  assign s1_move   = in_valid_q && (!tok.emit || out_free);
  assign in_stall_o = in_valid_q && !s1_move;
  assign in_accept = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (s1_move) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      st_q       <= STATE_RESET;
    end else begin
      in_valid_q <= in_valid_d;
      if (s1_move) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      eoi_q  <= end_of_input_i;
      byte_q <= text_byte_i;
    end
  end

  csvtok_out_reg u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (s1_move && tok.emit),
    .tok_i        (tok),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .free_o       (out_free),
    .token_kind_o (token_kind_o),
    .char_value_o (char_value_o)
  );

  // Error mode swallows every byte until end of input.
  a_error_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !eoi_q && st_q.mode == MODE_ERROR) |-> !tok.emit)
    else $error("token produced in error mode");

  // End of input always leaves the parser in its reset state.
  a_eoi_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_move && eoi_q) |=> (st_q.mode == MODE_PLAIN && !st_q.field_has_chars &&
                            !st_q.record_has_fields))
    else $error("parser not reset after end of input");

  // Only field characters carry a nonzero character value.
  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && token_kind_o != KIND_CHAR) |-> char_value_o == 8'h00)
    else $error("nonzero character on a non-character token");

  // A token is never loaded over a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_move && tok.emit) |-> (!out_valid_o || !out_stall_i))
    else $error("result register overwritten");

endmodule

// ===== design/csvtok_step.sv =====
// Combinational parser step: the current state and one word give the next state and a token.
// It depends on csvtok_pkg.
module csvtok_step (
  input  csvtok_pkg::parse_state_t cur_i,
  input  logic                     end_of_input_i,
  input  logic [7:0]               text_byte_i,
  output csvtok_pkg::parse_state_t nxt_o,
  output csvtok_pkg::token_t       tok_o
);
  import csvtok_pkg::*;

  logic run_plain;

  always_comb begin
    nxt_o     = cur_i;
    tok_o     = '{emit: 1'b0, kind: KIND_CHAR, char_value: 8'h00};
    run_plain = 1'b0;

    if (end_of_input_i) begin
      if (cur_i.mode == MODE_QUOTED) begin
        tok_o.emit = 1'b1;
        tok_o.kind = KIND_UNTERMINATED;
      end else if (cur_i.mode != MODE_ERROR &&
                   (cur_i.field_has_chars || cur_i.record_has_fields)) begin
        tok_o.emit = 1'b1;
        tok_o.kind = KIND_RECORD_END;
      end
      nxt_o = STATE_RESET;
    end else begin
      case (cur_i.mode)
        MODE_QUOTED: begin
          if (text_byte_i == CH_QUOTE) begin
            nxt_o.mode = MODE_PENDING;
          end else begin
            nxt_o.field_has_chars = 1'b1;
            tok_o.emit            = 1'b1;
            tok_o.char_value      = text_byte_i;
          end
        end
        MODE_PENDING: begin
          if (text_byte_i == CH_QUOTE) begin
            // A doubled quote stands for one literal quote.
            nxt_o.mode            = MODE_QUOTED;
            nxt_o.field_has_chars = 1'b1;
            tok_o.emit            = 1'b1;
            tok_o.char_value      = CH_QUOTE;
          end else begin
            nxt_o.mode = MODE_PLAIN;
            run_plain  = 1'b1;
          end
        end
        MODE_ERROR: begin
          run_plain = 1'b0;
        end
        default: begin
          run_plain = 1'b1;
        end
      endcase

      if (run_plain) begin
        case (text_byte_i)
          CH_QUOTE: begin
            if (cur_i.field_has_chars) begin
              nxt_o.mode = MODE_ERROR;
              tok_o.emit = 1'b1;
              tok_o.kind = KIND_STRAY_QUOTE;
            end else begin
              nxt_o.mode = MODE_QUOTED;
            end
          end
          CH_COMMA: begin
            nxt_o.field_has_chars   = 1'b0;
            nxt_o.record_has_fields = 1'b1;
            tok_o.emit              = 1'b1;
            tok_o.kind              = KIND_FIELD_END;
          end
          CH_LF: begin
            nxt_o.field_has_chars   = 1'b0;
            nxt_o.record_has_fields = 1'b0;
            tok_o.emit              = 1'b1;
            tok_o.kind              = KIND_RECORD_END;
          end
          CH_CR: begin
            tok_o.emit = 1'b0;
          end
          default: begin
            nxt_o.field_has_chars = 1'b1;
            tok_o.emit            = 1'b1;
            tok_o.char_value      = text_byte_i;
          end
        endcase
      end
    end
  end

endmodule

// ===== design/csvtok_out_reg.sv =====
// Result register of the CSV tokenizer: it holds one token until the sink takes it.
// It depends on csvtok_pkg.
module csvtok_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  csvtok_pkg::token_t tok_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic               free_o,
  output logic [2:0]         token_kind_o,
  output logic [7:0]         char_value_o
);
  import csvtok_pkg::*;

  logic       valid_q, valid_d;
  kind_e      kind_q;
  logic [7:0] char_q;

  // The slot can take a new word when it is empty or when its word leaves in this cycle.
  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      kind_q <= tok_i.kind;
      char_q <= tok_i.char_value;
    end
  end

  assign out_valid_o  = valid_q;
  assign token_kind_o = kind_q;
  assign char_value_o = char_q;

endmodule
